[src/sha512_pkg.sv]
// sha512 package: types, round constants, initial value and round functions
// no dependencies
package sha512_pkg;

   localparam int WordWidth = 64;
   localparam int NumRounds = 80;

   typedef logic [WordWidth-1:0] word_type;

   typedef enum logic [1:0] {
      MODE_MESSAGE = 2'd0,
      MODE_LOAD    = 2'd1,
      MODE_RESTORE = 2'd2,
      MODE_UNUSED  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_INIT,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
   } core_ctl_type;

   function automatic word_type round_k(input logic [6:0] t);
      word_type k;
      unique case (t)
         7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
         7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
         7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
         7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
         7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
         7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
         7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
         7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
         7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
         7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
         7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
         7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
         7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
         7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
         7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
         7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
         7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
         7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
         7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
         7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
         7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
         7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
         7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
         7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
         7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
         7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
         7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
         7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
         7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
         7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
         7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
         7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
         7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
         7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
         7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
         7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
         7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
         7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
         7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
         7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
         default: k = '0;
      endcase
      return k;
   endfunction

   function automatic word_type std_iv(input logic [2:0] i);
      word_type v;
      unique case (i)
         3'd0: v = 64'h6a09e667f3bcc908;
         3'd1: v = 64'hbb67ae8584caa73b;
         3'd2: v = 64'h3c6ef372fe94f82b;
         3'd3: v = 64'ha54ff53a5f1d36f1;
         3'd4: v = 64'h510e527fade682d1;
         3'd5: v = 64'h9b05688c2b3e6c1f;
         3'd6: v = 64'h1f83d9abfb41bd6b;
         default: v = 64'h5be0cd19137e2179;
      endcase
      return v;
   endfunction

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (WordWidth - n));
   endfunction

endpackage

[src/sha512_if.sv]
// valid/ready channel interface carrying a generic payload
// depends on nothing
interface sha512_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[src/sha512_core.sv]
// sha512 compression core: one round per cycle on a shared round unit
// depends on sha512_pkg
module sha512_core (
   input  logic                     clock,
   input  logic                     reset,
   input  sha512_pkg::core_ctl_type ctl,
   input  sha512_pkg::word_type     block_in [16],
   input  sha512_pkg::word_type     chain_in [8],
   output sha512_pkg::word_type     chain_out [8],
   output logic                     done
);
   import sha512_pkg::*;

   word_type   w_ff [16];
   word_type   v_ff [8];
   logic [6:0] t_ff;
   logic       run_ff;
   word_type   x2, x15, s0, s1, wnew, wt, t1, t2;
   word_type   a, b, c, d, e, f, g, h;

   assign {a, b, c, d} = {v_ff[0], v_ff[1], v_ff[2], v_ff[3]};
   assign {e, f, g, h} = {v_ff[4], v_ff[5], v_ff[6], v_ff[7]};

   always_comb begin
      x2   = w_ff[14];
      x15  = w_ff[1];
      s1   = rotr(x2, 19) ^ rotr(x2, 61) ^ (x2 >> 6);
      s0   = rotr(x15, 1) ^ rotr(x15, 8) ^ (x15 >> 7);
      wnew = w_ff[0] + s0 + w_ff[9] + s1;
      wt   = (t_ff < 7'd16) ? w_ff[t_ff[3:0]] : wnew;
      t1   = h + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41)) + (g ^ (e & (f ^ g)))
             + round_k(t_ff) + wt;
      t2   = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39)) + ((a & b) | (c & (a | b)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         t_ff   <= '0;
      end else if (ctl.start) begin
         run_ff <= 1'b1;
         t_ff   <= '0;
      end else if (run_ff) begin
         t_ff <= t_ff + 7'd1;
         if (t_ff == 7'(NumRounds - 1)) begin
            run_ff <= 1'b0;
         end
      end
   end

   // window shifts only once schedule expansion starts
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         w_ff <= block_in;
         v_ff <= chain_in;
      end else if (run_ff) begin
         v_ff <= '{t1 + t2, a, b, c, d + t1, e, f, g};
         if (t_ff >= 7'd16) begin
            for (int i = 0; i < 15; i++) begin
               w_ff[i] <= w_ff[i+1];
            end
            w_ff[15] <= wnew;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         chain_out[i] = chain_in[i] + v_ff[i];
      end
   end

   assign done = ctl.busy & ~run_ff & ~ctl.start;
endmodule

[src/sha512_stream_hasher.sv]
// sha512 stream hasher top level: block buffer, padding sequencer, digest output
// depends on sha512_pkg, sha512_if, sha512_core
//
//   channel | dir | payload
//   req     | in  | mode, data_word, valid_bytes, last, state_index
//   rsp     | out | digest_word, word_index, last_word
//
// a message word is taken while idle; one that completes a block is followed by
// start, 80 rounds on the shared round unit, done and chain update
// a last word, unless it is empty with no data before it, runs one or two padded blocks, then 8 output transfers
// req_ready is low while a block compresses or digest words are pending
// reset is synchronous and restores the standard initial value
module sha512_stream_hasher (
   input logic clock,
   input logic reset,
   sha512_if.sink   req,
   sha512_if.source rsp
);
   import sha512_pkg::*;

   state_type    state_ff, state_in;
   word_type     chain_ff [8];
   word_type     buf_ff [16];
   logic [3:0]   pos_ff;
   logic [63:0]  total_ff;
   logic         fin_ff;
   logic         extra_ff;
   logic         mark_ff;
   logic [2:0]   out_idx_ff;
   word_type     chain_new [8];
   logic         core_done;
   core_ctl_type ctl;

   logic [1:0]  r_mode;
   word_type    r_data;
   logic [3:0]  r_nb, nb;
   logic        r_last;
   logic [2:0]  r_idx;
   logic        acc;
   logic        len_fits;
   logic [63:0] tot_new;
   word_type    masked, mask;

   assign {r_mode, r_data, r_nb, r_last, r_idx} = req.payload;
   assign acc = req.valid & req.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign ctl.start = (state_ff == ST_INIT);
   assign ctl.busy  = (state_ff == ST_ROUND);
   assign len_fits  = (5'(pos_ff) + 5'(mark_ff)) <= 5'd14;

   sha512_core u_core (
      .clock(clock), .reset(reset), .ctl(ctl), .block_in(buf_ff),
      .chain_in(chain_ff), .chain_out(chain_new), .done(core_done)
   );

   always_comb begin
      nb      = (r_nb > 4'd8) ? 4'd8 : r_nb;
      tot_new = total_ff + 64'(nb);
      mask    = (nb == 4'd0) ? '0 : ~(64'h0) << (7'd64 - {nb, 3'b000});
      masked  = r_data & mask;
      if (nb < 4'd8) begin
         masked = masked | (64'h80 << (6'd56 - {nb[2:0], 3'b000}));
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc && mode_type'(r_mode) == MODE_MESSAGE) begin
               if (!r_last) begin
                  if (pos_ff == 4'd15) state_in = ST_INIT;
               end else if (!(nb == 4'd0 && total_ff == 64'd0)) begin
                  state_in = (pos_ff == 4'd15) ? ST_INIT : ST_PAD;
               end
            end
         end
         ST_PAD:   state_in = ST_INIT;
         ST_INIT:  state_in = ST_ROUND;
         ST_ROUND: if (core_done) state_in = ST_FOLD;
         ST_FOLD: begin
            if (extra_ff)    state_in = ST_PAD;
            else if (fin_ff) state_in = ST_EMIT;
            else             state_in = ST_IDLE;
         end
         ST_EMIT: if (rsp.ready && out_idx_ff == 3'd7) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         total_ff   <= '0;
         fin_ff     <= 1'b0;
         extra_ff   <= 1'b0;
         mark_ff    <= 1'b0;
         out_idx_ff <= '0;
         for (int i = 0; i < 8; i++) chain_ff[i] <= std_iv(3'(i));
      end else begin
         unique case (state_ff)
            ST_IDLE: if (acc) begin
               unique case (mode_type'(r_mode))
                  MODE_LOAD:    chain_ff[r_idx] <= r_data;
                  MODE_RESTORE: for (int i = 0; i < 8; i++) chain_ff[i] <= std_iv(3'(i));
                  MODE_UNUSED:  ;
                  MODE_MESSAGE: begin
                     if (!r_last) begin
                        total_ff       <= total_ff + 64'd8;
                        buf_ff[pos_ff] <= r_data;
                        pos_ff         <= pos_ff + 4'd1;
                     end else if (!(nb == 4'd0 && total_ff == 64'd0)) begin
                        total_ff       <= tot_new;
                        fin_ff         <= 1'b1;
                        buf_ff[pos_ff] <= masked;
                        pos_ff         <= pos_ff + 4'd1;
                        // full last word: marker goes in the next slot
                        mark_ff        <= (nb == 4'd8);
                        extra_ff       <= (pos_ff == 4'd15);
                     end
                  end
                  default: ;
               endcase
            end
            ST_PAD: begin
               // fill rest of block; length fits when words plus marker <= 14
               for (int i = 0; i < 16; i++) begin
                  if (i == 15 && len_fits) begin
                     buf_ff[i] <= {total_ff[60:0], 3'b000};
                  end else if (mark_ff && 4'(i) == pos_ff) begin
                     buf_ff[i] <= 64'h8000_0000_0000_0000;
                  end else if (4'(i) >= pos_ff) begin
                     buf_ff[i] <= '0;
                  end
               end
               mark_ff  <= 1'b0;
               extra_ff <= !len_fits;
            end
            ST_FOLD: begin
               chain_ff <= chain_new;
               pos_ff   <= '0;
            end
            ST_EMIT: if (rsp.ready) begin
               out_idx_ff <= out_idx_ff + 3'd1;
               if (out_idx_ff == 3'd7) begin
                  fin_ff   <= 1'b0;
                  total_ff <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp.valid   = (state_ff == ST_EMIT);
   assign rsp.payload = {chain_ff[out_idx_ff], out_idx_ff, out_idx_ff == 3'd7};

   property p_ready_idle;
      @(posedge clock) disable iff (reset) req.ready |-> !rsp.valid;
   endproperty
   a_ready_idle: assert property (p_ready_idle) else $error("ready while emitting");

   property p_emit_order;
      @(posedge clock) disable iff (reset)
         (rsp.valid && rsp.ready && out_idx_ff != 3'd7) |=> rsp.valid;
   endproperty
   a_emit_order: assert property (p_emit_order) else $error("digest cut short");

   property p_core_start;
      @(posedge clock) disable iff (reset) ctl.start |=> state_ff == ST_ROUND;
   endproperty
   a_core_start: assert property (p_core_start) else $error("core start lost");
endmodule
